// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the walker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/ptw_pkg.sv =====
// ---------------------------------------------------------------------------
// ptw_pkg
// Types, constants and helpers shared by the page table walker modules.
// ---------------------------------------------------------------------------
package ptw_pkg;

    // Address and entry geometry
    localparam int PA_BITS        = 52;
    localparam int ADDR_PORT_BITS = 52;
    localparam int VA_BITS        = 48;
    localparam int ENTRY_BITS     = 64;
    localparam int IDX_BITS       = 9;
    localparam int ENTRY_SHIFT    = 3;
    localparam int PAGE_SHIFT     = 12;
    localparam int LARGE_SHIFT    = 21;
    localparam int FRAME_BITS     = PA_BITS - PAGE_SHIFT;

    // Index positions of each level within the virtual address
    localparam int SHIFT_TOP   = 39;
    localparam int SHIFT_UPPER = 30;
    localparam int SHIFT_DIR   = 21;
    localparam int SHIFT_LEAF  = 12;

    // Entry flag bits
    localparam int PRESENT_POS = 0;
    localparam int LARGE_POS   = 7;

    // Input item kinds
    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    // Result item kinds
    localparam logic RESULT_READ = 1'b0;
    localparam logic RESULT_DONE = 1'b1;

    // Walk levels (level whose entry is awaited)
    localparam logic [1:0] LEVEL_TOP   = 2'd0;
    localparam logic [1:0] LEVEL_UPPER = 2'd1;
    localparam logic [1:0] LEVEL_DIR   = 2'd2;
    localparam logic [1:0] LEVEL_LEAF  = 2'd3;

    // Front-to-back queue
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Classified item handed from front to back
    typedef struct packed {
        logic                  is_req;    // new translation request
        logic [VA_BITS-1:0]    vaddr;     // request: virtual address
        logic [PA_BITS-1:0]    req_addr;  // request: first entry address
        logic [FRAME_BITS-1:0] frame;     // response: entry frame bits
        logic                  entry_ok;  // response: read good and present
        logic                  big_page;  // response: large page bit
    } work_t;

    // Table index of a virtual address for one level
    function automatic logic [IDX_BITS-1:0] table_index(
        input logic [VA_BITS-1:0] va,
        input logic [1:0]         level
    );
        logic [IDX_BITS-1:0] idx;
        case (level)
            LEVEL_TOP:   idx = va[SHIFT_TOP   +: IDX_BITS];
            LEVEL_UPPER: idx = va[SHIFT_UPPER +: IDX_BITS];
            LEVEL_DIR:   idx = va[SHIFT_DIR   +: IDX_BITS];
            default:     idx = va[SHIFT_LEAF  +: IDX_BITS];
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/core/ptw_front.sv =====
// ---------------------------------------------------------------------------
// ptw_front
// Classifies incoming items and precomputes the first entry address.
// ---------------------------------------------------------------------------
module ptw_front (
    input  logic                           kind,
    input  logic [ptw_pkg::VA_BITS-1:0]    vaddr_in,
    input  logic [ptw_pkg::ADDR_PORT_BITS-1:0] root_table,
    input  logic [ptw_pkg::ENTRY_BITS-1:0] read_data,
    input  logic                           read_ok,
    output ptw_pkg::work_t                 item
);

    logic [ptw_pkg::PA_BITS-1:0]  root_pa;
    logic [ptw_pkg::IDX_BITS-1:0] top_idx;
    logic [ptw_pkg::PA_BITS-1:0]  top_ofs;

    // First read: root plus scaled top-level index, wrapping at PA_BITS
    assign root_pa = root_table[ptw_pkg::PA_BITS-1:0];
    assign top_idx = ptw_pkg::table_index(vaddr_in, ptw_pkg::LEVEL_TOP);
    assign top_ofs = ptw_pkg::PA_BITS'({top_idx, {ptw_pkg::ENTRY_SHIFT{1'b0}}});

    // Pack the classified item
    always_comb begin
        item.is_req   = (kind == ptw_pkg::KIND_REQUEST);
        item.vaddr    = vaddr_in;
        item.req_addr = root_pa + top_ofs;
        item.frame    = read_data[ptw_pkg::PA_BITS-1:ptw_pkg::PAGE_SHIFT];
        item.entry_ok = read_ok & read_data[ptw_pkg::PRESENT_POS];
        item.big_page = read_data[ptw_pkg::LARGE_POS];
    end

endmodule

// ===== rtl/core/ptw_queue.sv =====
// ---------------------------------------------------------------------------
// ptw_queue
// Short FIFO between front and back; push and pop in the same cycle.
// ---------------------------------------------------------------------------
module ptw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  ptw_pkg::work_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ptw_pkg::work_t pop_item
);

    ptw_pkg::work_t mem_reg [ptw_pkg::QUEUE_DEPTH];

    logic [ptw_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ptw_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ptw_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                               do_push, do_pop;

    assign push_ready = (count_reg != ptw_pkg::QUEUE_CNT_BITS'(ptw_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == ptw_pkg::QUEUE_PTR_BITS'(ptw_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == ptw_pkg::QUEUE_PTR_BITS'(ptw_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/ptw_back.sv =====
// ---------------------------------------------------------------------------
// ptw_back
// Walk state machine: steps the walk per item and registers the result.
// ---------------------------------------------------------------------------
module ptw_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  ptw_pkg::work_t              item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        res_kind,
    output logic [ptw_pkg::PA_BITS-1:0] res_read_addr,
    output logic [ptw_pkg::PA_BITS-1:0] res_paddr,
    output logic                        res_fault
);

    // Walk state
    logic                        busy_reg, busy_next;
    logic [1:0]                  level_reg, level_next;
    logic [ptw_pkg::VA_BITS-1:0] vaddr_reg, vaddr_next;

    // Output register
    logic                        valid_reg, valid_next;
    logic                        kind_reg, kind_next;
    logic [ptw_pkg::PA_BITS-1:0] raddr_reg, raddr_next;
    logic [ptw_pkg::PA_BITS-1:0] paddr_reg, paddr_next;
    logic                        fault_reg, fault_next;

    logic                         fire;
    logic [1:0]                   level_up;
    logic [ptw_pkg::IDX_BITS-1:0] next_idx;
    logic [ptw_pkg::PA_BITS-1:0]  next_addr;
    logic [ptw_pkg::PA_BITS-1:0]  large_pa;
    logic [ptw_pkg::PA_BITS-1:0]  page_pa;

    // Take an item whenever the output register is free or draining
    assign item_ready = !valid_reg || m_ready;
    assign fire       = item_valid && item_ready;

    // Address candidates; low bits of the bases are zero, so joins replace adds
    assign level_up  = 2'(level_reg + 2'd1);
    assign next_idx  = ptw_pkg::table_index(vaddr_reg, level_up);
    assign next_addr = {item.frame, next_idx, {ptw_pkg::ENTRY_SHIFT{1'b0}}};
    assign large_pa  = {item.frame[ptw_pkg::FRAME_BITS-1:
                                   ptw_pkg::LARGE_SHIFT-ptw_pkg::PAGE_SHIFT],
                        vaddr_reg[ptw_pkg::LARGE_SHIFT-1:0]};
    assign page_pa   = {item.frame, vaddr_reg[ptw_pkg::PAGE_SHIFT-1:0]};

    // One walk step per item
    always_comb begin
        busy_next  = busy_reg;
        level_next = level_reg;
        vaddr_next = vaddr_reg;
        valid_next = valid_reg && !m_ready;
        kind_next  = kind_reg;
        raddr_next = raddr_reg;
        paddr_next = paddr_reg;
        fault_next = fault_reg;
        if (fire) begin
            if (item.is_req) begin
                // New request drops any walk in progress
                vaddr_next = item.vaddr;
                valid_next = 1'b1;
                if (item.req_addr == '0) begin
                    busy_next  = 1'b0;
                    level_next = ptw_pkg::LEVEL_TOP;
                    kind_next  = ptw_pkg::RESULT_DONE;
                    raddr_next = '0;
                    paddr_next = '0;
                    fault_next = 1'b1;
                end else begin
                    busy_next  = 1'b1;
                    level_next = ptw_pkg::LEVEL_TOP;
                    kind_next  = ptw_pkg::RESULT_READ;
                    raddr_next = item.req_addr;
                    paddr_next = '0;
                    fault_next = 1'b0;
                end
            end else if (busy_reg) begin
                valid_next = 1'b1;
                raddr_next = '0;
                kind_next  = ptw_pkg::RESULT_DONE;
                busy_next  = 1'b0;
                level_next = ptw_pkg::LEVEL_TOP;
                if (!item.entry_ok) begin
                    // Failed read or entry not present
                    paddr_next = '0;
                    fault_next = 1'b1;
                end else if (level_reg == ptw_pkg::LEVEL_LEAF) begin
                    paddr_next = page_pa;
                    fault_next = (page_pa == '0);
                end else if (level_reg == ptw_pkg::LEVEL_DIR && item.big_page) begin
                    // 2 MiB page
                    paddr_next = large_pa;
                    fault_next = (large_pa == '0);
                end else if (next_addr == '0) begin
                    paddr_next = '0;
                    fault_next = 1'b1;
                end else begin
                    busy_next  = 1'b1;
                    level_next = level_up;
                    kind_next  = ptw_pkg::RESULT_READ;
                    raddr_next = next_addr;
                    paddr_next = '0;
                    fault_next = 1'b0;
                end
            end
            // response while idle: dropped, no result
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= ptw_pkg::LEVEL_TOP;
            vaddr_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            vaddr_reg <= vaddr_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        raddr_reg <= raddr_next;
        paddr_reg <= paddr_next;
        fault_reg <= fault_next;
    end

    assign m_valid       = valid_reg;
    assign res_kind      = kind_reg;
    assign res_read_addr = raddr_reg;
    assign res_paddr     = paddr_reg;
    assign res_fault     = fault_reg;

endmodule

// ===== rtl/core/four_level_page_table_walker_unit.sv =====
// ---------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Four-level page table walker for 48-bit virtual addresses.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake          | Items
//  s_      | in  | s_valid / s_ready  | translation requests, read responses
//  m_      | out | m_valid / m_ready  | entry read requests, finished walks
//
//  One item per cycle sustained while m_ready stays high; a result item shows
//  on m_ once its input item has passed the queue entry and then the walk
//  step into the output register.
//  The walk state advances once per item in the back end, which sets the rate.
//  Reset: aresetn synchronous, active low; queue empty, walker idle.
//  A stalled m_ side holds the output register, fills the two-entry queue,
//  then drops s_ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module four_level_page_table_walker_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [ptw_pkg::VA_BITS-1:0]         s_vaddr,
    input  logic [ptw_pkg::ADDR_PORT_BITS-1:0]  s_root_table,
    input  logic [ptw_pkg::ENTRY_BITS-1:0]      s_read_data,
    input  logic                                s_read_ok,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_result_kind,
    output logic [ptw_pkg::ADDR_PORT_BITS-1:0]  m_read_addr,
    output logic [ptw_pkg::ADDR_PORT_BITS-1:0]  m_paddr,
    output logic                                m_fault
);

    ptw_pkg::work_t              front_item;
    ptw_pkg::work_t              back_item;
    logic                        back_valid;
    logic                        back_ready;
    logic [ptw_pkg::PA_BITS-1:0] read_addr;
    logic [ptw_pkg::PA_BITS-1:0] done_pa;

    // Front: classify items
    ptw_front u_front (
        .kind      (s_kind),
        .vaddr_in  (s_vaddr),
        .root_table(s_root_table),
        .read_data (s_read_data),
        .read_ok   (s_read_ok),
        .item      (front_item)
    );

    // Queue between front and back
    ptw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(s_valid),
        .push_ready(s_ready),
        .push_item (front_item),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_item  (back_item)
    );

    // Back: walk state and result register
    ptw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .res_kind     (m_result_kind),
        .res_read_addr(read_addr),
        .res_paddr    (done_pa),
        .res_fault    (m_fault)
    );

    assign m_read_addr = ptw_pkg::ADDR_PORT_BITS'(read_addr);
    assign m_paddr     = ptw_pkg::ADDR_PORT_BITS'(done_pa);

    // A finished walk faults exactly when its address is zero
    `ASSERT_IMPLIES(a_done_fault, aclk, aresetn,
        m_valid && (m_result_kind == ptw_pkg::RESULT_DONE),
        m_fault == (m_paddr == '0))

    // A read request never carries a zero address, a result address or a fault
    `ASSERT_IMPLIES(a_read_clean, aclk, aresetn,
        m_valid && (m_result_kind == ptw_pkg::RESULT_READ),
        (m_read_addr != '0) && (m_paddr == '0) && !m_fault)

    // A finished walk reports no read address
    `ASSERT_IMPLIES(a_done_no_read, aclk, aresetn,
        m_valid && (m_result_kind == ptw_pkg::RESULT_DONE),
        m_read_addr == '0)

endmodule
